// ===== hdl/angle_speed_estimator_top_defines.svh =====
// Assertion macros shared by the angle speed estimator RTL.
`ifndef ANGLE_SPEED_ESTIMATOR_TOP_DEFINES_SVH
`define ANGLE_SPEED_ESTIMATOR_TOP_DEFINES_SVH

// Same-cycle implication, checked on clk_i and disabled while rst_ni is low.
`define ASE_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on clk_i and disabled while rst_ni is low.
`define ASE_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/ase_pkg.sv =====
// Types and constants of the angle speed estimator.
package ase_pkg;

  localparam int unsigned AngleW    = 15;
  localparam int unsigned TimeW     = 32;
  localparam int unsigned StepW     = 16;
  localparam int unsigned SpeedW    = 31;
  localparam int unsigned GainW     = 16;
  localparam int unsigned DelayW    = 8;
  localparam int unsigned CfgIdxW   = 2;
  localparam int unsigned CfgDataW  = 16;
  localparam int unsigned FracW     = 16;
  localparam int unsigned DvdW      = AngleW + FracW;
  localparam int unsigned ErrW      = SpeedW + 1;
  localparam int unsigned ProdW     = ErrW + GainW;
  localparam int unsigned DivCntW   = 5;
  localparam int unsigned DivSteps  = DvdW;

  localparam logic [GainW-1:0]  GainReset  = GainW'(655);
  localparam logic [DelayW-1:0] DelayReset = DelayW'(4);

  localparam logic [CfgIdxW-1:0] CfgGain  = CfgIdxW'(0);
  localparam logic [CfgIdxW-1:0] CfgDelay = CfgIdxW'(1);

  localparam logic signed [SpeedW-1:0] SpeedMax = {1'b0, {(SpeedW-1){1'b1}}};
  localparam logic signed [SpeedW-1:0] SpeedMin = {1'b1, {(SpeedW-1){1'b0}}};

  typedef enum logic [2:0] {
    StIdle,
    StDiv,
    StErr,
    StMul,
    StAcc,
    StOut
  } state_e;

  typedef struct packed {
    logic accept;
    logic div_en;
    logic err_en;
    logic mul_en;
    logic acc_en;
    logic out_load;
  } ctrl_t;

endpackage

// ===== hdl/angle_speed_estimator_top.sv =====
// Angle speed estimator: angle difference over time difference, smoothed by an exponential average.
//
//   Channel  Direction  Handshake                 Payload
//   in       to block   in_valid_i / in_stall_o   angle_sample_i, time_us_i
//   out      from block out_valid_o / out_stall_i angle_out_o, speed_out_o, angle_step_o
//   cfg      to block   cfg_valid_i / cfg_ready_o cfg_index_i, cfg_wdata_i
//
// An item with a nonzero time difference passes through these steps in order: it is
// accepted, the radix-2 restoring divider makes one quotient bit per cycle for all
// 31 quotient bits, then come the error, the gain multiply, the average update and the
// output load. A zero time difference skips the arithmetic and goes straight to the
// output load. Reset clears the stored angle, time and speed and loads the register
// defaults. A stalled output beat holds the block in its output step, so no new
// item is taken until the pending result has moved into the output register.
`include "angle_speed_estimator_top_defines.svh"

module angle_speed_estimator_top (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic [ase_pkg::AngleW-1:0]          angle_sample_i,
  input  logic [ase_pkg::TimeW-1:0]           time_us_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic [ase_pkg::AngleW-1:0]          angle_out_o,
  output logic signed [ase_pkg::SpeedW-1:0]   speed_out_o,
  output logic signed [ase_pkg::StepW-1:0]    angle_step_o,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [ase_pkg::CfgIdxW-1:0]         cfg_index_i,
  input  logic [ase_pkg::CfgDataW-1:0]        cfg_wdata_i
);

  ase_pkg::state_e state_q, state_d;
  ase_pkg::ctrl_t  ctrl;

  // Configuration registers.
  logic [ase_pkg::GainW-1:0]  gain_q;
  logic [ase_pkg::DelayW-1:0] delay_q;

  // Model state.
  logic [ase_pkg::AngleW-1:0]        last_angle_q;
  logic [ase_pkg::TimeW-1:0]         last_time_q;
  logic signed [ase_pkg::SpeedW-1:0] acc_q, acc_d;

  // Work registers of the current item.
  logic [ase_pkg::DivCntW-1:0]       cnt_q;
  logic [ase_pkg::TimeW-1:0]         dt_q;
  logic [ase_pkg::TimeW-1:0]         rem_q;
  logic [ase_pkg::DvdW-1:0]          quo_q;
  logic                              neg_q;
  logic [ase_pkg::AngleW-1:0]        angle_q;
  logic signed [ase_pkg::StepW-1:0]  step_q;
  logic signed [ase_pkg::ErrW-1:0]   err_q;
  logic signed [ase_pkg::ProdW-1:0]  prod_q;

  // Output register.
  logic                              out_valid_q;
  logic [ase_pkg::AngleW-1:0]        angle_out_q;
  logic signed [ase_pkg::SpeedW-1:0] speed_out_q;
  logic signed [ase_pkg::StepW-1:0]  angle_step_q;

  // Front end: sample time, time difference and the wrapped angle difference.
  logic [ase_pkg::TimeW-1:0]         t_now;
  logic [ase_pkg::TimeW-1:0]         dt_now;
  logic signed [ase_pkg::StepW:0]    diff_raw;
  logic signed [ase_pkg::StepW:0]    diff_wrap;
  logic signed [ase_pkg::StepW-1:0]  step_now;
  logic [ase_pkg::StepW-1:0]         abs_step;

  assign t_now    = time_us_i - ase_pkg::TimeW'(delay_q);
  assign dt_now   = t_now - last_time_q;
  assign diff_raw = $signed({2'b00, angle_sample_i}) - $signed({2'b00, last_angle_q});

  always_comb begin
    if (diff_raw > 17'sd16384) begin
      diff_wrap = diff_raw - 17'sd32768;
    end else if (diff_raw < -17'sd16384) begin
      diff_wrap = diff_raw + 17'sd32768;
    end else begin
      diff_wrap = diff_raw;
    end
  end

  assign step_now = diff_wrap[ase_pkg::StepW-1:0];
  assign abs_step = step_now[ase_pkg::StepW-1] ? ase_pkg::StepW'(-step_now)
                                               : ase_pkg::StepW'(step_now);

  // One restoring divider step: shift in the next dividend bit, subtract if it fits.
  logic [ase_pkg::TimeW:0]   rem_sh;
  logic                      fits;
  logic [ase_pkg::TimeW:0]   rem_sub;
  logic [ase_pkg::TimeW-1:0] rem_nx;

  assign rem_sh  = {rem_q, quo_q[ase_pkg::DvdW-1]};
  assign fits    = rem_sh >= {1'b0, dt_q};
  assign rem_sub = rem_sh - {1'b0, dt_q};
  assign rem_nx  = fits ? rem_sub[ase_pkg::TimeW-1:0] : rem_sh[ase_pkg::TimeW-1:0];

  // Signed, saturated instantaneous speed. Only +2^30 can overflow the range.
  logic [ase_pkg::DvdW-1:0]          q_mag;
  logic signed [ase_pkg::SpeedW-1:0] q_speed;

  always_comb begin
    q_mag = quo_q;
    if (!neg_q && q_mag[ase_pkg::DvdW-1]) begin
      q_speed = ase_pkg::SpeedMax;
    end else if (neg_q) begin
      q_speed = $signed(ase_pkg::SpeedW'(-q_mag));
    end else begin
      q_speed = $signed(ase_pkg::SpeedW'(q_mag));
    end
  end

  // Gain multiply; the gain is unsigned, so it is widened with a zero sign bit.
  logic signed [ase_pkg::ProdW:0] prod_full;
  assign prod_full = err_q * $signed({1'b0, gain_q});

  // Average update, rounded to nearest with ties upward, then clamped.
  logic signed [ase_pkg::ProdW-1:0]  prod_rnd;
  logic signed [ase_pkg::ErrW-1:0]   inc;
  logic signed [ase_pkg::ErrW:0]     acc_sum;

  assign prod_rnd = prod_q + $signed(ase_pkg::ProdW'(32768));
  assign inc      = prod_rnd[ase_pkg::ProdW-1:ase_pkg::FracW];
  assign acc_sum  = $signed({{2{acc_q[ase_pkg::SpeedW-1]}}, acc_q})
                  + $signed({inc[ase_pkg::ErrW-1], inc});

  always_comb begin
    if (acc_sum > $signed({{2{1'b0}}, ase_pkg::SpeedMax})) begin
      acc_d = ase_pkg::SpeedMax;
    end else if (acc_sum < $signed({{2{1'b1}}, ase_pkg::SpeedMin})) begin
      acc_d = ase_pkg::SpeedMin;
    end else begin
      acc_d = acc_sum[ase_pkg::SpeedW-1:0];
    end
  end

  // Sequencer: next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      ase_pkg::StIdle: begin
        if (in_valid_i) begin
          state_d = (dt_now == '0) ? ase_pkg::StOut : ase_pkg::StDiv;
        end
      end
      ase_pkg::StDiv: begin
        if (cnt_q == '0) begin
          state_d = ase_pkg::StErr;
        end
      end
      ase_pkg::StErr: state_d = ase_pkg::StMul;
      ase_pkg::StMul: state_d = ase_pkg::StAcc;
      ase_pkg::StAcc: state_d = ase_pkg::StOut;
      ase_pkg::StOut: begin
        if (!out_valid_q || !out_stall_i) begin
          state_d = ase_pkg::StIdle;
        end
      end
      default: state_d = ase_pkg::StIdle;
    endcase
  end

  // Sequencer: control outputs.
  always_comb begin
    ctrl = '0;
    case (state_q)
      ase_pkg::StIdle: ctrl.accept   = in_valid_i;
      ase_pkg::StDiv:  ctrl.div_en   = 1'b1;
      ase_pkg::StErr:  ctrl.err_en   = 1'b1;
      ase_pkg::StMul:  ctrl.mul_en   = 1'b1;
      ase_pkg::StAcc:  ctrl.acc_en   = 1'b1;
      ase_pkg::StOut:  ctrl.out_load = !out_valid_q || !out_stall_i;
      default:         ctrl = '0;
    endcase
  end

  assign in_stall_o  = (state_q != ase_pkg::StIdle);
  assign cfg_ready_o = 1'b1;

  // Control state and model state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ase_pkg::StIdle;
      gain_q       <= ase_pkg::GainReset;
      delay_q      <= ase_pkg::DelayReset;
      last_angle_q <= '0;
      last_time_q  <= '0;
      acc_q        <= '0;
      cnt_q        <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_valid_i && cfg_ready_o) begin
        case (cfg_index_i)
          ase_pkg::CfgGain:  gain_q  <= cfg_wdata_i[ase_pkg::GainW-1:0];
          ase_pkg::CfgDelay: delay_q <= cfg_wdata_i[ase_pkg::DelayW-1:0];
          default: ;
        endcase
      end
      if (ctrl.accept) begin
        last_angle_q <= angle_sample_i;
        last_time_q  <= t_now;
        cnt_q        <= ase_pkg::DivCntW'(ase_pkg::DivSteps - 1);
      end else if (ctrl.div_en) begin
        cnt_q <= cnt_q - 1'b1;
      end
      if (ctrl.acc_en) begin
        acc_q <= acc_d;
      end
      if (ctrl.out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (ctrl.accept) begin
      dt_q    <= dt_now;
      rem_q   <= '0;
      quo_q   <= {abs_step[ase_pkg::AngleW-1:0], {ase_pkg::FracW{1'b0}}};
      neg_q   <= step_now[ase_pkg::StepW-1];
      angle_q <= angle_sample_i;
      step_q  <= step_now;
    end else if (ctrl.div_en) begin
      rem_q <= rem_nx;
      quo_q <= {quo_q[ase_pkg::DvdW-2:0], fits};
    end
    if (ctrl.err_en) begin
      err_q <= $signed({q_speed[ase_pkg::SpeedW-1], q_speed})
             - $signed({acc_q[ase_pkg::SpeedW-1], acc_q});
    end
    if (ctrl.mul_en) begin
      prod_q <= prod_full[ase_pkg::ProdW-1:0];
    end
    if (ctrl.out_load) begin
      angle_out_q  <= angle_q;
      speed_out_q  <= acc_q;
      angle_step_q <= step_q;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign angle_out_o  = angle_out_q;
  assign speed_out_o  = speed_out_q;
  assign angle_step_o = angle_step_q;

  // An accepted item either starts the divider or goes straight to its output step.
  `ASE_ASSERT_NEXT(a_accept_next, ctrl.accept,
    (state_q == ase_pkg::StDiv) || (state_q == ase_pkg::StOut), "bad state after accept")
  // The divider remainder always stays below the divisor.
  `ASE_ASSERT_NOW(a_rem_bound, state_q == ase_pkg::StDiv, rem_q < dt_q,
    "divider remainder out of range")
  // A result is loaded only when the output register is free or being drained.
  `ASE_ASSERT_NOW(a_out_free, ctrl.out_load, !out_valid_q || !out_stall_i,
    "output register overwritten")
  // The running speed changes only in the average update step.
  `ASE_ASSERT_NEXT(a_acc_hold, state_q != ase_pkg::StAcc, $stable(acc_q),
    "running speed changed outside its update step")

endmodule
